@@ hdl/dhm_pkg.sv @@
// Package: shared types and constants of the hit merger.
`default_nettype none
package dhm_pkg;
  localparam int unsigned MaxEntriesDef = 64;
  localparam int unsigned KeyW  = 30;
  localparam int unsigned EnW   = 20;
  localparam int unsigned SumEW = 26;
  localparam int unsigned TimeW = 24;
  localparam int unsigned PosW  = 16;
  localparam int unsigned WSumW = 43;
  localparam int unsigned ProdW = 37;

  typedef enum logic {
    ReqAdd   = 1'b0,
    ReqFlush = 1'b1
  } req_e;

  typedef struct packed {
    logic             req;
    logic [KeyW-1:0]  key;
    logic [EnW-1:0]   energy;
    logic [TimeW-1:0] hit_time;
    logic [PosW-1:0]  pos_x;
    logic [PosW-1:0]  pos_y;
    logic [PosW-1:0]  pos_z;
  } cmd_t;

  // one table entry as stored in RAM
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [SumEW-1:0] energy;
    logic [TimeW-1:0] hit_time;
    logic [WSumW-1:0] sx;
    logic [WSumW-1:0] sy;
    logic [WSumW-1:0] sz;
  } entry_t;
endpackage
`default_nettype wire

@@ hdl/dhm_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
`default_nettype none
module dhm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ hdl/dhm_front.sv @@
// Front end: takes transactions, packs the key and queues commands.
`default_nettype none
module dhm_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output      logic              ready_o,
  input  wire logic              req_type_i,
  input  wire logic [15:0]       track_id_i,
  input  wire logic [7:0]        bar_index_i,
  input  wire logic [3:0]        layer_index_i,
  input  wire logic [1:0]        side_index_i,
  input  wire logic [19:0]       energy_i,
  input  wire logic [23:0]       hit_time_i,
  input  wire logic [15:0]       pos_x_i,
  input  wire logic [15:0]       pos_y_i,
  input  wire logic [15:0]       pos_z_i,
  output      logic              cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output      dhm_pkg::cmd_t     cmd_o
);
  // two-entry queue
  dhm_pkg::cmd_t slot_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       push, pop;
  dhm_pkg::cmd_t in_cmd;

  always_comb begin
    in_cmd          = '0;
    in_cmd.req      = req_type_i;
    in_cmd.key      = {track_id_i, bar_index_i, layer_index_i, side_index_i};
    in_cmd.energy   = energy_i;
    in_cmd.hit_time = hit_time_i;
    in_cmd.pos_x    = pos_x_i;
    in_cmd.pos_y    = pos_y_i;
    in_cmd.pos_z    = pos_z_i;
  end

  assign ready_o     = (cnt_q != 2'd2);
  assign push        = valid_i & ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o & cmd_ready_i;
  assign cmd_o       = slot_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= in_cmd;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 2'd0) else $error("pop from empty queue");
`endif
endmodule
`default_nettype wire

@@ hdl/dhm_div.sv @@
// Serial signed divider: 43-bit dividend by 26-bit unsigned divisor, truncating.
`default_nettype none
module dhm_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [dhm_pkg::WSumW-1:0] num_i,
  input  wire logic [dhm_pkg::SumEW-1:0] den_i,
  output      logic                      busy_o,
  output      logic [15:0]               quo_o
);
  localparam int unsigned NW = dhm_pkg::WSumW;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0]   mag_q;
  logic [NW-1:0]   quo_q;
  logic [dhm_pkg::SumEW:0] rem_q;
  logic [dhm_pkg::SumEW-1:0] den_q;
  logic            neg_q;
  logic [CW-1:0]   cnt_q;
  logic [dhm_pkg::SumEW:0] trial;
  logic [NW-1:0]   q_signed;

  assign busy_o   = (cnt_q != '0);
  assign trial    = {rem_q[dhm_pkg::SumEW-1:0], mag_q[NW-1]};
  assign q_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quo_o    = (den_q == '0) ? 16'd0 : q_signed[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(NW);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NW-1];
      mag_q <= num_i[NW-1] ? (~num_i + 1'b1) : num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_o) begin
      mag_q <= {mag_q[NW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/dhm_back.sv @@
// Back end: key search, merge read-modify-write and flush with centroid division.
`default_nettype none
module dhm_back #(
  parameter int unsigned MaxEntries = dhm_pkg::MaxEntriesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cmd_valid_i,
  output      logic               cmd_ready_o,
  input  wire dhm_pkg::cmd_t      cmd_i,
  output      logic               valid_o,
  input  wire logic               ready_i,
  output      logic [15:0]        out_track_o,
  output      logic [7:0]         out_bar_o,
  output      logic [3:0]         out_layer_o,
  output      logic [1:0]         out_side_o,
  output      logic [25:0]        total_energy_o,
  output      logic [23:0]        first_time_o,
  output      logic [15:0]        centroid_x_o,
  output      logic [15:0]        centroid_y_o,
  output      logic [15:0]        centroid_z_o,
  output      logic               is_empty_o,
  output      logic               hits_dropped_o,
  output      logic               last_item_o
);
  localparam int unsigned AW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CW = $clog2(MaxEntries + 1);
  localparam int unsigned EW = $bits(dhm_pkg::entry_t);

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StMerge = 8'b0000_0010,
    StRead  = 8'b0000_0100,
    StDivX  = 8'b0000_1000,
    StDivY  = 8'b0001_0000,
    StDivZ  = 8'b0010_0000,
    StOut   = 8'b0100_0000,
    StWait  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // keys live in flops for the parallel match; the rest sits in RAM
  logic [dhm_pkg::KeyW-1:0] key_q [MaxEntries];
  logic [CW-1:0]  count_q;
  logic           ovf_q;
  logic [AW-1:0]  idx_q;
  logic           hit_q;
  dhm_pkg::cmd_t  cmd_q;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  dhm_pkg::entry_t ram_wdata, ram_rdata, ent_q;

  logic [dhm_pkg::ProdW-1:0] px_q, py_q, pz_q;

  logic           match;
  logic [AW-1:0]  match_idx;

  logic           div_start, div_busy;
  logic [dhm_pkg::WSumW-1:0] div_num;
  logic [15:0]    div_quo;
  logic [15:0]    cx_q, cy_q, cz_q;

  logic           out_v_q;
  logic           last_flag;

  always_comb begin
    match     = 1'b0;
    match_idx = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      if ((CW'(i) < count_q) && (key_q[i] == cmd_i.key) && !match) begin
        match     = 1'b1;
        match_idx = AW'(i);
      end
    end
  end

  assign cmd_ready_o = (state_q == StIdle) && !out_v_q;
  assign last_flag   = ((CW+1)'(idx_q) + (CW+1)'(1)) == (CW+1)'(count_q);

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = ent_q.sx;
    case (state_q)
      StIdle: begin
        if (cmd_valid_i && cmd_ready_o) begin
          if (cmd_i.req == dhm_pkg::ReqAdd) begin
            state_d = StMerge;
          end else if (count_q == '0) begin
            state_d = StOut;
          end else begin
            state_d = StRead;
          end
        end
      end
      StMerge: state_d = StIdle;
      StRead: begin
        state_d = StWait;
      end
      StWait: begin
        div_start = 1'b1;
        div_num   = ram_rdata.sx;
        state_d   = StDivX;
      end
      StDivX: begin
        if (!div_busy) begin
          div_start = 1'b1;
          div_num   = ent_q.sy;
          state_d   = StDivY;
        end
      end
      StDivY: begin
        if (!div_busy) begin
          div_start = 1'b1;
          div_num   = ent_q.sz;
          state_d   = StDivZ;
        end
      end
      StDivZ: begin
        if (!div_busy) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_v_q) begin
          state_d = StOut;
        end
        if (out_v_q && ready_i) begin
          state_d = last_item_o ? StIdle : StRead;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // merge write: the registered products and the RAM read data meet in StMerge
  always_comb begin
    ram_wdata          = ram_rdata;
    ram_wdata.key      = cmd_q.key;
    if (hit_q) begin
      ram_wdata.energy   = ram_rdata.energy + dhm_pkg::SumEW'(cmd_q.energy);
      ram_wdata.hit_time = (cmd_q.hit_time < ram_rdata.hit_time) ?
                           cmd_q.hit_time : ram_rdata.hit_time;
      ram_wdata.sx = ram_rdata.sx + {{6{px_q[36]}}, px_q};
      ram_wdata.sy = ram_rdata.sy + {{6{py_q[36]}}, py_q};
      ram_wdata.sz = ram_rdata.sz + {{6{pz_q[36]}}, pz_q};
    end else begin
      ram_wdata.energy   = dhm_pkg::SumEW'(cmd_q.energy);
      ram_wdata.hit_time = cmd_q.hit_time;
      ram_wdata.sx = {{6{px_q[36]}}, px_q};
      ram_wdata.sy = {{6{py_q[36]}}, py_q};
      ram_wdata.sz = {{6{pz_q[36]}}, pz_q};
    end
  end

  assign ram_we    = (state_q == StMerge) &&
                     (hit_q || (count_q < CW'(MaxEntries)));
  assign ram_waddr = idx_q;
  assign ram_raddr = (state_q == StIdle) ? match_idx : idx_q;

  dhm_ram #(.Width(EW), .Depth(MaxEntries)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dhm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   ((state_q == StWait) ? ram_rdata.energy : ent_q.energy),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      ovf_q   <= 1'b0;
      out_v_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          if (cmd_valid_i && cmd_ready_o) begin
            // a flush walks the table from the first entry
            if (cmd_i.req == dhm_pkg::ReqFlush) begin
              idx_q <= '0;
            end else begin
              idx_q <= match ? match_idx : count_q[AW-1:0];
            end
          end
        end
        StMerge: begin
          if (!hit_q) begin
            if (count_q < CW'(MaxEntries)) begin
              count_q <= count_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        StDivZ: begin
          if (!div_busy) begin
            out_v_q <= 1'b1;
          end
        end
        StOut: begin
          if (!out_v_q) begin
            out_v_q <= 1'b1;
          end else if (ready_i) begin
            out_v_q <= 1'b0;
            if (last_item_o) begin
              count_q <= '0;
              ovf_q   <= 1'b0;
              idx_q   <= '0;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && cmd_valid_i && cmd_ready_o) begin
      cmd_q <= cmd_i;
      hit_q <= match;
      px_q  <= dhm_pkg::ProdW'($signed(cmd_i.pos_x) * $signed({1'b0, cmd_i.energy}));
      py_q  <= dhm_pkg::ProdW'($signed(cmd_i.pos_y) * $signed({1'b0, cmd_i.energy}));
      pz_q  <= dhm_pkg::ProdW'($signed(cmd_i.pos_z) * $signed({1'b0, cmd_i.energy}));
    end
    if (state_q == StMerge && ram_we && !hit_q) begin
      key_q[idx_q] <= cmd_q.key;
    end
    if (state_q == StWait) begin
      ent_q <= ram_rdata;
    end
    if (state_q == StDivX && !div_busy) begin
      cx_q <= div_quo;
    end
    if (state_q == StDivY && !div_busy) begin
      cy_q <= div_quo;
    end
    if (state_q == StDivZ && !div_busy) begin
      cz_q <= div_quo;
    end
  end

  wire empty_flush = (count_q == '0);

  assign valid_o        = out_v_q && (state_q == StOut);
  assign is_empty_o     = empty_flush;
  assign hits_dropped_o = ovf_q;
  assign last_item_o    = empty_flush ? 1'b1 : last_flag;
  assign out_track_o    = empty_flush ? '0 : ent_q.key[29:14];
  assign out_bar_o      = empty_flush ? '0 : ent_q.key[13:6];
  assign out_layer_o    = empty_flush ? '0 : ent_q.key[5:2];
  assign out_side_o     = empty_flush ? '0 : ent_q.key[1:0];
  assign total_energy_o = empty_flush ? '0 : ent_q.energy;
  assign first_time_o   = empty_flush ? '0 : ent_q.hit_time;
  assign centroid_x_o   = empty_flush ? '0 : cx_q;
  assign centroid_y_o   = empty_flush ? '0 : cy_q;
  assign centroid_z_o   = empty_flush ? '0 : cz_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxEntries)) else $error("entry count beyond table");
  a_no_cmd_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StOut |-> !cmd_ready_o) else $error("command taken during flush");
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && ready_i && last_item_o) |=> count_q == '0 && !ovf_q)
    else $error("table not cleared after flush");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
`endif
endmodule
`default_nettype wire

@@ hdl/detector_hit_merger_unit.sv @@
// Top level of the detector hit merger.
// Usage:
//   Input channel (valid_i/ready_o) takes one transaction per hit or flush.
//   req_type_i = 0 adds a hit: merged into the entry with the same
//   track/bar/layer/side key, or placed in a new entry in first-seen order.
//   Hits with a new key are dropped when the table is full; the loss is
//   reported with hits_dropped_o on the next flush.
//   req_type_i = 1 flushes: one output transaction per entry in first-seen
//   order, last_item_o on the final one; an empty table gives a single
//   transaction with is_empty_o set.
// Timing:
//   A hit occupies the back end for a key match plus RAM read, then a
//   write-back in StMerge; a two-deep command queue decouples input from the back end.
//   Each flushed entry is read from RAM, then passes three 43-step serial
//   divisions for the centroids, then waits for ready_i.
// Reset clears the entry count, the overflow flag and the queue; table RAM
// is not cleared. While the receiver holds ready_i low the result is held
// and the queue fills, then ready_o drops.
`default_nettype none
module detector_hit_merger_unit #(
  parameter int unsigned MAX_ENTRIES = dhm_pkg::MaxEntriesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output      logic        ready_o,
  input  wire logic        req_type_i,
  input  wire logic [15:0] track_id_i,
  input  wire logic [7:0]  bar_index_i,
  input  wire logic [3:0]  layer_index_i,
  input  wire logic [1:0]  side_index_i,
  input  wire logic [19:0] energy_i,
  input  wire logic [23:0] hit_time_i,
  input  wire logic [15:0] pos_x_i,
  input  wire logic [15:0] pos_y_i,
  input  wire logic [15:0] pos_z_i,
  output      logic        valid_o,
  input  wire logic        ready_i,
  output      logic [15:0] out_track_o,
  output      logic [7:0]  out_bar_o,
  output      logic [3:0]  out_layer_o,
  output      logic [1:0]  out_side_o,
  output      logic [25:0] total_energy_o,
  output      logic [23:0] first_time_o,
  output      logic [15:0] centroid_x_o,
  output      logic [15:0] centroid_y_o,
  output      logic [15:0] centroid_z_o,
  output      logic        is_empty_o,
  output      logic        hits_dropped_o,
  output      logic        last_item_o
);
  logic          cmd_valid, cmd_ready;
  dhm_pkg::cmd_t cmd;

  dhm_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .req_type_i, .track_id_i,
    .bar_index_i, .layer_index_i, .side_index_i, .energy_i, .hit_time_i,
    .pos_x_i, .pos_y_i, .pos_z_i,
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  dhm_back #(.MaxEntries(MAX_ENTRIES)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .valid_o, .ready_i, .out_track_o, .out_bar_o, .out_layer_o, .out_side_o,
    .total_energy_o, .first_time_o, .centroid_x_o, .centroid_y_o,
    .centroid_z_o, .is_empty_o, .hits_dropped_o, .last_item_o
  );
endmodule
`default_nettype wire

@@ tb/sv/tb_detector_hit_merger_unit.sv @@
// Testbench of the detector hit merger: random and directed hits and flushes against a predictor.
`timescale 1ns / 100ps
module tb_detector_hit_merger_unit;

  localparam int unsigned TableDepth = 64;
  localparam longint unsigned CycleLimit = 3000000;

  typedef struct {
    dhm_pkg::req_e    req;
    logic [15:0]      track;
    logic [7:0]       bar;
    logic [3:0]       layer;
    logic [1:0]       side;
    logic [19:0]      energy;
    logic [23:0]      hit_time;
    logic [15:0]      px;
    logic [15:0]      py;
    logic [15:0]      pz;
  } hit_t;

  typedef struct {
    logic [15:0] track;
    logic [7:0]  bar;
    logic [3:0]  layer;
    logic [1:0]  side;
    logic [25:0] energy;
    logic [23:0] first_time;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] cz;
    logic        empty;
    logic        dropped;
    logic        last;
  } merged_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic ready_o;
  logic req_type_i = 1'b0;
  logic [15:0] track_id_i = '0;
  logic [7:0]  bar_index_i = '0;
  logic [3:0]  layer_index_i = '0;
  logic [1:0]  side_index_i = '0;
  logic [19:0] energy_i = '0;
  logic [23:0] hit_time_i = '0;
  logic [15:0] pos_x_i = '0;
  logic [15:0] pos_y_i = '0;
  logic [15:0] pos_z_i = '0;
  logic valid_o;
  logic ready_i = 1'b0;
  logic [15:0] out_track_o;
  logic [7:0]  out_bar_o;
  logic [3:0]  out_layer_o;
  logic [1:0]  out_side_o;
  logic [25:0] total_energy_o;
  logic [23:0] first_time_o;
  logic [15:0] centroid_x_o;
  logic [15:0] centroid_y_o;
  logic [15:0] centroid_z_o;
  logic is_empty_o;
  logic hits_dropped_o;
  logic last_item_o;

  detector_hit_merger_unit uut (
    .clk_i, .rst_ni, .valid_i, .ready_o, .req_type_i, .track_id_i, .bar_index_i,
    .layer_index_i, .side_index_i, .energy_i, .hit_time_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .valid_o, .ready_i, .out_track_o, .out_bar_o, .out_layer_o, .out_side_o,
    .total_energy_o, .first_time_o, .centroid_x_o, .centroid_y_o, .centroid_z_o,
    .is_empty_o, .hits_dropped_o, .last_item_o
  );

  // predictor copy of the merge table
  logic [29:0] tbl_key [TableDepth];
  logic [25:0] tbl_energy [TableDepth];
  logic [23:0] tbl_time [TableDepth];
  longint      tbl_sx [TableDepth];
  longint      tbl_sy [TableDepth];
  longint      tbl_sz [TableDepth];
  int          tbl_count = 0;
  bit          tbl_overflow = 1'b0;

  merged_t pending_q[$];
  int errors = 0;
  int items_sent = 0;
  int flushes_sent = 0;
  int results_seen = 0;
  int drops_seen = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;
  longint unsigned cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout at %0t", $time);
      $display("detector_hit_merger_unit: mismatch");
      $finish;
    end
  end

  function automatic logic [15:0] centroid_of(longint sum, logic [25:0] e);
    longint c;
    c = 0;
    if (e != 0) c = sum / longint'(e);
    return c[15:0];
  endfunction

  task automatic predict_merge(hit_t h);
    logic [29:0] k;
    longint x, y, z, e;
    k = {h.track, h.bar, h.layer, h.side};
    e = longint'(h.energy);
    x = longint'($signed(h.px));
    y = longint'($signed(h.py));
    z = longint'($signed(h.pz));
    if (h.req == dhm_pkg::ReqFlush) begin
      merged_t r;
      flushes_sent++;
      if (tbl_count == 0) begin
        r = '{default: '0};
        r.empty = 1'b1;
        r.dropped = tbl_overflow;
        r.last = 1'b1;
        pending_q.insert(pending_q.size(), r);
      end else begin
        for (int i = 0; i < tbl_count; i++) begin
          {r.track, r.bar, r.layer, r.side} = tbl_key[i];
          r.energy = tbl_energy[i];
          r.first_time = tbl_time[i];
          r.cx = centroid_of(tbl_sx[i], tbl_energy[i]);
          r.cy = centroid_of(tbl_sy[i], tbl_energy[i]);
          r.cz = centroid_of(tbl_sz[i], tbl_energy[i]);
          r.empty = 1'b0;
          r.dropped = tbl_overflow;
          r.last = (i == tbl_count - 1);
          pending_q.insert(pending_q.size(), r);
        end
      end
      if (tbl_overflow) drops_seen++;
      tbl_count = 0;
      tbl_overflow = 1'b0;
      return;
    end
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] == k) begin
        tbl_energy[i] += h.energy;
        if (h.hit_time < tbl_time[i]) tbl_time[i] = h.hit_time;
        tbl_sx[i] += x * e;
        tbl_sy[i] += y * e;
        tbl_sz[i] += z * e;
        return;
      end
    end
    if (tbl_count >= TableDepth) begin
      tbl_overflow = 1'b1;
      return;
    end
    tbl_key[tbl_count] = k;
    tbl_energy[tbl_count] = 26'(h.energy);
    tbl_time[tbl_count] = h.hit_time;
    tbl_sx[tbl_count] = x * e;
    tbl_sy[tbl_count] = y * e;
    tbl_sz[tbl_count] = z * e;
    tbl_count++;
  endtask

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_item(hit_t h);
    while ($urandom_range(99) < send_idle) begin
      valid_i = 1'b0;
      @(negedge clk_i);
    end
    req_type_i = h.req;
    track_id_i = h.track;
    bar_index_i = h.bar;
    layer_index_i = h.layer;
    side_index_i = h.side;
    energy_i = h.energy;
    hit_time_i = h.hit_time;
    pos_x_i = h.px;
    pos_y_i = h.py;
    pos_z_i = h.pz;
    valid_i = 1'b1;
    #1;
    while (!ready_o) begin
      @(negedge clk_i);
      #1;
    end
    predict_merge(h);
    items_sent++;
    @(negedge clk_i);
    valid_i = 1'b0;
  endtask

  task automatic chk(string name, longint e, longint a);
    if (e != a) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, e, a);
    end
  endtask

  // receiver: ready changes at the falling edge, results are checked at the rising edge
  initial begin
    merged_t r;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        ready_i = 1'b0;
      end else begin
        ready_i = ($urandom_range(99) >= recv_idle);
      end
      @(posedge clk_i);
      if (rst_ni && valid_o && ready_i) begin
        results_seen++;
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, track %0h", $time, out_track_o);
        end else begin
          r = pending_q.pop_front();
          chk("out_track", r.track, out_track_o);
          chk("out_bar", r.bar, out_bar_o);
          chk("out_layer", r.layer, out_layer_o);
          chk("out_side", r.side, out_side_o);
          chk("total_energy", r.energy, total_energy_o);
          chk("first_time", r.first_time, first_time_o);
          chk("centroid_x", r.cx, centroid_x_o);
          chk("centroid_y", r.cy, centroid_y_o);
          chk("centroid_z", r.cz, centroid_z_o);
          chk("is_empty", r.empty, is_empty_o);
          chk("hits_dropped", r.dropped, hits_dropped_o);
          chk("last_item", r.last, last_item_o);
        end
      end
    end
  end

  function automatic hit_t rand_hit();
    hit_t h;
    h.req = dhm_pkg::ReqAdd;
    h.track = 16'($urandom);
    h.bar = 8'($urandom);
    h.layer = 4'($urandom);
    h.side = 2'($urandom);
    case ($urandom_range(7))
      0: h.energy = '0;
      1: h.energy = '1;
      2: h.energy = 20'($urandom_range(15));
      default: h.energy = 20'($urandom);
    endcase
    h.hit_time = ($urandom_range(9) == 0) ? '1 : 24'($urandom);
    h.px = ($urandom_range(9) == 0) ? 16'h8000 : 16'($urandom);
    h.py = ($urandom_range(9) == 0) ? 16'h7fff : 16'($urandom);
    h.pz = 16'($urandom);
    return h;
  endfunction

  function automatic hit_t flush_req();
    hit_t h;
    h = rand_hit();
    h.req = dhm_pkg::ReqFlush;
    return h;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    hit_t h;
    send_item(flush_req());
    h = rand_hit();
    h.track = '1; h.bar = '1; h.layer = '1; h.side = '1;
    h.energy = '1; h.hit_time = '1;
    h.px = 16'h7fff; h.py = 16'h8000; h.pz = 16'h8000;
    send_item(h);
    // same key, earlier time, opposite extremes on x and y
    h.energy = 20'd3; h.hit_time = 24'd5;
    h.px = 16'h8000; h.py = 16'h7fff; h.pz = 16'h0001;
    send_item(h);
    h.hit_time = 24'd9;
    send_item(h);
    h = rand_hit();
    h.track = '0; h.bar = '0; h.layer = '0; h.side = '0;
    h.energy = '0; h.hit_time = '0;
    send_item(h);
    h.energy = '0; h.hit_time = 24'd100;
    send_item(h);
    h = rand_hit();
    h.energy = 20'd7; h.px = 16'hfffd; h.py = 16'd3; h.pz = 16'hfff9;
    send_item(h);
    send_item(flush_req());
    send_item(flush_req());
  endtask

  // fill every entry, then a new key is lost and a known key still merges
  task automatic test_table_full();
    hit_t h, first;
    for (int i = 0; i < TableDepth; i++) begin
      h = rand_hit();
      h.track = 16'(i); h.bar = 8'($urandom);
      if (i == 0) first = h;
      send_item(h);
    end
    h = rand_hit();
    h.track = 16'hbeef;
    send_item(h);
    first.energy = 20'd1000; first.hit_time = '0;
    send_item(first);
    send_item(flush_req());
    send_item(flush_req());
  endtask

  // well-formed events: hits from a small key pool, then a flush; some stray keys
  task automatic test_random_events(int n_items);
    hit_t pool[4];
    hit_t h;
    int sent, n_hits, n_keys;
    sent = 0;
    while (sent < n_items) begin
      n_keys = $urandom_range(1, 4);
      for (int k = 0; k < n_keys; k++) pool[k] = rand_hit();
      n_hits = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 7);
      for (int j = 0; j < n_hits; j++) begin
        h = rand_hit();
        if ($urandom_range(9) < 7) begin
          h.track = pool[$urandom_range(n_keys - 1)].track;
          h.bar = pool[0].bar; h.layer = pool[0].layer; h.side = pool[0].side;
        end
        send_item(h);
        sent++;
      end
      send_item(flush_req());
      sent++;
    end
  endtask

  task automatic test_back_pressure();
    hit_t h;
    wait_drained();
    for (int j = 0; j < 3; j++) send_item(rand_hit());
    send_item(flush_req());
    hold_cycles = 2000;
    for (int j = 0; j < 12; j++) begin
      h = rand_hit();
      h.track = 16'(j % 5);
      send_item(h);
    end
    send_item(flush_req());
    // sender stops here until the backlog has drained
    wait_drained();
    send_item(rand_hit());
    send_item(flush_req());
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_table_full();
    send_idle = 6; recv_idle = 75;
    test_random_events(90);
    send_idle = 75; recv_idle = 6;
    test_random_events(90);
    send_idle = 0; recv_idle = 0;
    test_random_events(90);
    test_back_pressure();
    valid_i = 1'b0;
    wait_drained();
    repeat (400) @(negedge clk_i);
    $display("%0d transactions in (%0d flushes), %0d results checked, %0d events with drops",
             items_sent, flushes_sent, results_seen, drops_seen);
    $display("covered merges, full table, empty flushes, zero energy and output stalls");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("detector_hit_merger_unit: match");
    end else begin
      $display("detector_hit_merger_unit: mismatch");
    end
    $finish;
  end
endmodule
